>>> design/pnsc_pkg.sv
package pnsc_pkg;

   localparam int WORD_COUNT_DEFAULT = 1024;
   localparam int CODES_PER_WORD     = 10;
   localparam int CODE_W             = 3;
   localparam int WORD_W             = CODES_PER_WORD * CODE_W;
   localparam int POS_W              = 14;
   localparam int KIND_W             = 2;
   localparam int LANE_W             = 4;
   // largest position / 10 is 1638
   localparam int IDX_W              = 11;
   // n * 52429 >> 19 equals n / 10 for every 14-bit n
   localparam int RECIP_W            = 16;
   localparam int RECIP_SHIFT        = 19;
   localparam logic [RECIP_W-1:0] RECIP10 = 16'd52429;

   localparam logic [KIND_W-1:0] KIND_SET   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_GET   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_COUNT = 2'd2;

   typedef enum logic [1:0] {
      OP_SET,
      OP_GET,
      OP_COUNT,
      OP_ZERO
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SET,
      ST_GET,
      ST_COUNT
   } st_type;

   typedef struct packed {
      op_type              op;
      logic [IDX_W-1:0]    first_idx;
      logic [LANE_W-1:0]   first_lane;
      logic [IDX_W-1:0]    last_idx;
      logic [LANE_W-1:0]   last_lane;
      logic [CODE_W-1:0]   code;
   } cmd_type;

   function automatic logic [IDX_W-1:0] div10(input logic [POS_W-1:0] n);
      logic [POS_W+RECIP_W-1:0] prod;
      prod = (POS_W+RECIP_W)'(n) * (POS_W+RECIP_W)'(RECIP10);
      return prod[RECIP_SHIFT +: IDX_W];
   endfunction

   function automatic logic [LANE_W-1:0] mod10(input logic [POS_W-1:0] n,
                                                input logic [IDX_W-1:0] q);
      logic [POS_W-1:0] rem;
      rem = n - POS_W'(q) * POS_W'(CODES_PER_WORD);
      return rem[LANE_W-1:0];
   endfunction

endpackage

>>> design/packed_nucleotide_store_counter.sv
// set: accepted, then one word read and one write, no result
// get: passes the command queue, the ram read and the result register when the back end is idle
// count: reads the spanned words one after another through the single ram read port
// a two-entry command queue lets new items in while the back end works
// reset is synchronous; afterwards a clearing pass writes zero to all WORD_COUNT
// words, one per cycle, and no item is accepted until it ends
module packed_nucleotide_store_counter
   import pnsc_pkg::*;
#(
   parameter int WORD_COUNT = WORD_COUNT_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [POS_W-1:0]    req_position,
   input  logic [POS_W-1:0]    req_end_position,
   input  logic [CODE_W-1:0]   req_nucleotide,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [POS_W-1:0]    rsp_value
);

   localparam int Capacity = WORD_COUNT * CODES_PER_WORD;

   logic    clearing;
   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd_head;

   pnsc_front #(
      .WORD_COUNT (WORD_COUNT)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .clearing         (clearing),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_position     (req_position),
      .req_end_position (req_end_position),
      .req_nucleotide   (req_nucleotide),
      .cmd_valid        (cmd_valid),
      .cmd_head         (cmd_head),
      .cmd_pop          (cmd_pop)
   );

   pnsc_back #(
      .WORD_COUNT (WORD_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .clearing  (clearing),
      .cmd_valid (cmd_valid),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_value (rsp_value)
   );

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_ready && !rsp_valid && !cmd_pop)
      else $error("activity during clearing pass");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command popped from empty queue");

   a_value_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_value) <= 32'(Capacity))
      else $error("result above store capacity");

   a_reset_clears: assert property (@(posedge clock)
      $fell(reset) |-> clearing)
      else $error("no clearing pass after reset");

endmodule

>>> design/pnsc_ram.sv
module pnsc_ram #(
   parameter int WIDTH = 30,
   parameter int DEPTH = 1024
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/pnsc_front.sv
module pnsc_front
   import pnsc_pkg::*;
#(
   parameter int WORD_COUNT = WORD_COUNT_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                clearing,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [POS_W-1:0]    req_position,
   input  logic [POS_W-1:0]    req_end_position,
   input  logic [CODE_W-1:0]   req_nucleotide,
   output logic                cmd_valid,
   output cmd_type             cmd_head,
   input  logic                cmd_pop
);

   localparam int Capacity = WORD_COUNT * CODES_PER_WORD;

   cmd_type          dec_cmd;
   logic             dec_keep;
   logic             in_cap;
   logic [POS_W-1:0] end_clamped;
   logic [POS_W-1:0] end_last;

   cmd_type          q_ff [2];
   cmd_type          q_in [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             push;

   // decode
   always_comb begin
      in_cap      = 32'(req_position) < 32'(Capacity);
      end_clamped = (32'(req_end_position) > 32'(Capacity)) ? POS_W'(Capacity)
                                                             : req_end_position;
      end_last    = end_clamped - POS_W'(1);

      dec_cmd.first_idx  = div10(req_position);
      dec_cmd.first_lane = mod10(req_position, dec_cmd.first_idx);
      dec_cmd.last_idx   = div10(end_last);
      dec_cmd.last_lane  = mod10(end_last, dec_cmd.last_idx) + LANE_W'(1);
      dec_cmd.code       = req_nucleotide;
      dec_cmd.op         = OP_ZERO;
      dec_keep           = 1'b0;

      case (req_kind)
         KIND_SET: begin
            dec_cmd.op = OP_SET;
            dec_keep   = in_cap;
         end
         KIND_GET: begin
            dec_cmd.op = in_cap ? OP_GET : OP_ZERO;
            dec_keep   = 1'b1;
         end
         KIND_COUNT: begin
            dec_cmd.op = (req_position < end_clamped) ? OP_COUNT : OP_ZERO;
            dec_keep   = 1'b1;
         end
         default: begin
            dec_keep = 1'b0;
         end
      endcase
   end

   // two-entry queue
   assign req_ready = (cnt_ff != 2'd2) && !clearing;
   assign push      = req_valid && req_ready && dec_keep;
   assign cmd_valid = cnt_ff != 2'd0;
   assign cmd_head  = q_ff[rd_ptr_ff];

   always_comb begin
      q_in[0]   = q_ff[0];
      q_in[1]   = q_ff[1];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         q_in[wr_ptr_ff] = dec_cmd;
         wr_ptr_in       = !wr_ptr_ff;
      end
      if (cmd_pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push && !cmd_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!push && cmd_pop) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

>>> design/pnsc_back.sv
module pnsc_back
   import pnsc_pkg::*;
#(
   parameter int WORD_COUNT = WORD_COUNT_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   output logic                clearing,
   input  logic                cmd_valid,
   input  cmd_type             cmd_head,
   output logic                cmd_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [POS_W-1:0]    rsp_value
);

   localparam int AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

   st_type            state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [IDX_W-1:0]  cur_ff, cur_in;
   logic [POS_W-1:0]  total_ff, total_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]  rsp_value_ff, rsp_value_in;

   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [WORD_W-1:0] wr_data, rd_data;

   logic              out_free;
   logic              clr_last;
   logic              cur_last;
   logic [LANE_W-1:0] lo, hi;
   logic [LANE_W-1:0] hits;
   logic [WORD_W-1:0] set_word;

   pnsc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (WORD_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign clr_last = clr_ff == AW'(WORD_COUNT - 1);
   assign cur_last = cur_ff == cmd_ff.last_idx;
   assign clearing = state_ff == ST_CLEAR;

   // lane match count and lane replace
   always_comb begin
      lo       = (cur_ff == cmd_ff.first_idx) ? cmd_ff.first_lane : LANE_W'(0);
      hi       = cur_last ? cmd_ff.last_lane : LANE_W'(CODES_PER_WORD);
      hits     = '0;
      set_word = rd_data;
      for (int i = 0; i < CODES_PER_WORD; i++) begin
         if (LANE_W'(i) >= lo && LANE_W'(i) < hi &&
             rd_data[CODE_W*i +: CODE_W] == cmd_ff.code) begin
            hits = hits + LANE_W'(1);
         end
         if (LANE_W'(i) == cmd_ff.first_lane) begin
            set_word[CODE_W*i +: CODE_W] = cmd_ff.code;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_pop) begin
               case (cmd_head.op)
                  OP_SET:   state_in = ST_SET;
                  OP_GET:   state_in = ST_GET;
                  OP_COUNT: state_in = ST_COUNT;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_SET:   state_in = ST_IDLE;
         ST_GET:   state_in = ST_IDLE;
         ST_COUNT: begin
            if (cur_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // outputs and datapath
   always_comb begin
      cmd_pop      = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = AW'(cmd_ff.first_idx);
      wr_data      = set_word;
      rd_en        = 1'b0;
      rd_addr      = AW'(cmd_head.first_idx);
      cmd_in       = cmd_ff;
      cur_in       = cur_ff;
      total_in     = total_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + AW'(1);
         end
         ST_IDLE: begin
            cmd_pop  = cmd_valid && (cmd_head.op == OP_SET || out_free);
            rd_en    = cmd_pop;
            cmd_in   = cmd_pop ? cmd_head : cmd_ff;
            cur_in   = cmd_head.first_idx;
            total_in = '0;
            if (cmd_pop && cmd_head.op == OP_ZERO) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
            end
         end
         ST_SET: begin
            wr_en = 1'b1;
         end
         ST_GET: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = POS_W'(rd_data[CODE_W*cmd_ff.first_lane +: CODE_W]);
         end
         ST_COUNT: begin
            total_in = total_ff + POS_W'(hits);
            cur_in   = cur_ff + IDX_W'(1);
            rd_en    = !cur_last;
            rd_addr  = AW'(cur_in);
            if (cur_last) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = total_in;
            end
         end
         default: begin
            cmd_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      cur_ff       <= cur_in;
      total_ff     <= total_in;
      rsp_value_ff <= rsp_value_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

endmodule

>>> tb/packed_nucleotide_store_counter_tb.sv
module packed_nucleotide_store_counter_tb;
   import pnsc_pkg::*;

   localparam int WORDS     = WORD_COUNT_DEFAULT;
   localparam int CAPACITY  = WORDS * CODES_PER_WORD;
   localparam int POS_MAX   = (1 << POS_W) - 1;
   localparam int LIMIT     = 5_000_000;
   localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [KIND_W-1:0]   req_kind = KIND_SET;
   logic [POS_W-1:0]    req_position = '0;
   logic [POS_W-1:0]    req_end_position = '0;
   logic [CODE_W-1:0]   req_nucleotide = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [POS_W-1:0]    rsp_value;

   logic [WORD_W-1:0]   store_words [WORDS];
   logic [POS_W-1:0]    expected_values [$];

   int  n_errors = 0;
   int  n_sets = 0;
   int  n_gets = 0;
   int  n_counts = 0;
   int  n_ignored = 0;
   int  n_results = 0;
   int  cycle_count = 0;
   int  rx_hold = 0;
   bit  rx_idle = 1'b0;
   bit  tx_idle = 1'b0;

   packed_nucleotide_store_counter dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_position     (req_position),
      .req_end_position (req_end_position),
      .req_nucleotide   (req_nucleotide),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_value        (rsp_value)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      foreach (store_words[i]) store_words[i] = '0;
   end

   // store update and expected value for one accepted item
   function automatic void predict_item(input logic [KIND_W-1:0] kind,
                                        input int unsigned pos, input int unsigned endp,
                                        input logic [CODE_W-1:0] code);
      int unsigned first;
      int unsigned last;
      int unsigned lo;
      int unsigned hi;
      int unsigned total;
      logic [CODE_W-1:0] got;
      case (kind)
         KIND_SET: begin
            if (pos < CAPACITY) begin
               store_words[pos / CODES_PER_WORD][CODE_W * (pos % CODES_PER_WORD) +: CODE_W]
                  = code;
               n_sets++;
            end else begin
               n_ignored++;
            end
         end
         KIND_GET: begin
            got = '0;
            if (pos < CAPACITY)
               got = store_words[pos / CODES_PER_WORD]
                                [CODE_W * (pos % CODES_PER_WORD) +: CODE_W];
            expected_values.push_back(POS_W'(got));
            n_gets++;
         end
         KIND_COUNT: begin
            total = 0;
            if (endp > CAPACITY) endp = CAPACITY;
            if (pos < endp) begin
               first = pos / CODES_PER_WORD;
               last  = (endp - 1) / CODES_PER_WORD;
               for (int unsigned idx = first; idx <= last; idx++) begin
                  lo = (idx == first) ? pos % CODES_PER_WORD : 0;
                  hi = (idx == last) ? (endp - 1) % CODES_PER_WORD + 1 : CODES_PER_WORD;
                  for (int unsigned lane = lo; lane < hi; lane++)
                     if (store_words[idx][CODE_W * lane +: CODE_W] == code) total++;
               end
            end
            expected_values.push_back(POS_W'(total));
            n_counts++;
         end
         default: n_ignored++;
      endcase
   endfunction

   task automatic send_item(input logic [KIND_W-1:0] kind, input int pos, input int endp,
                            input int code);
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_position     <= POS_W'(pos);
      req_end_position <= POS_W'(endp);
      req_nucleotide   <= CODE_W'(code);
      do @(posedge clock); while (!req_ready);
      predict_item(kind, pos, endp, CODE_W'(code));
   endtask

   task automatic idle_gap(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   function automatic int tx_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!tx_idle || r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(15, 60);
   endfunction

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_values.size() != 0) @(posedge clock);
   endtask

   function automatic int pick_position();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(0, 199);
      if (r < 90) return $urandom_range(0, CAPACITY - 1);
      return $urandom_range(CAPACITY, POS_MAX);
   endfunction

   function automatic int pick_end(input int start);
      int r;
      int e;
      r = $urandom_range(0, 99);
      if (r < 5) return $urandom_range(0, start);
      if (r < 70) e = start + $urandom_range(1, 30);
      else if (r < 92) e = start + $urandom_range(1, 200);
      else if (r < 98) e = start + $urandom_range(200, 2000);
      else return $urandom_range(CAPACITY, POS_MAX);
      return (e > POS_MAX) ? POS_MAX : e;
   endfunction

   // returns 1 when the block acts on the item
   task automatic random_item(output bit used);
      int r;
      int pos;
      r   = $urandom_range(0, 99);
      pos = pick_position();
      idle_gap(tx_gap());
      if (r < 35) begin
         send_item(KIND_SET, pos, $urandom_range(0, POS_MAX), $urandom_range(0, 7));
         used = (pos < CAPACITY);
      end else if (r < 65) begin
         send_item(KIND_GET, pos, $urandom_range(0, POS_MAX), $urandom_range(0, 7));
         used = 1'b1;
      end else if (r < 95) begin
         if ($urandom_range(0, 9) < 8 && pos >= CAPACITY) pos = $urandom_range(0, 199);
         send_item(KIND_COUNT, pos, pick_end(pos), $urandom_range(0, 7));
         used = 1'b1;
      end else begin
         send_item(KIND_NONE, pos, $urandom_range(0, POS_MAX), $urandom_range(0, 7));
         used = 1'b0;
      end
   endtask

   task automatic random_run(input int items);
      int done;
      bit used;
      done = 0;
      while (done < items) begin
         random_item(used);
         if (used) done++;
      end
   endtask

   task automatic test_directed_edges();
      send_item(KIND_GET, 0, 0, 0);
      send_item(KIND_COUNT, 0, CAPACITY, 0);
      send_item(KIND_SET, 0, 0, 7);
      send_item(KIND_SET, CAPACITY - 1, 0, 5);
      send_item(KIND_SET, 9, POS_MAX, 6);
      send_item(KIND_SET, 10, 0, 3);
      send_item(KIND_SET, 11, 0, 1);
      send_item(KIND_SET, 12, 0, 2);
      send_item(KIND_SET, 13, 0, 4);
      send_item(KIND_SET, CAPACITY, 0, 1);
      send_item(KIND_SET, POS_MAX, POS_MAX, 7);
      send_item(KIND_NONE, POS_MAX, POS_MAX, 7);
      send_item(KIND_GET, CAPACITY - 1, 0, 0);
      send_item(KIND_GET, 0, POS_MAX, 7);
      send_item(KIND_GET, CAPACITY, 0, 0);
      send_item(KIND_GET, POS_MAX, POS_MAX, 7);
      send_item(KIND_COUNT, 0, POS_MAX, 5);
      send_item(KIND_COUNT, 5, 15, 6);
      send_item(KIND_COUNT, 20, 10, 0);
      send_item(KIND_COUNT, 7, 7, 0);
      send_item(KIND_COUNT, 0, 1, 7);
      send_item(KIND_COUNT, POS_MAX, POS_MAX, 0);
      send_item(KIND_COUNT, 9, 14, 1);
      send_item(KIND_COUNT, 10, 14, 2);
      send_item(KIND_COUNT, 3, 20, 4);
      send_item(KIND_COUNT, 1, CAPACITY, 0);
      send_item(KIND_COUNT, 10, 11, 3);
   endtask

   task automatic test_random_mix();
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      random_run(340);
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      random_run(170);
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      random_run(130);
   endtask

   task automatic test_full_backpressure();
      tx_idle = 1'b0;
      rx_hold = 400;
      for (int i = 0; i < 24; i++) begin
         if (i % 2 == 0) send_item(KIND_GET, $urandom_range(0, 199), 0, 0);
         else send_item(KIND_COUNT, i, i + $urandom_range(0, 40), $urandom_range(0, 7));
      end
   endtask

   task automatic test_drain_pause();
      tx_idle = 1'b1;
      random_run(20);
      wait_drained();
      random_run(20);
   endtask

   // result side: random stalls while rx_idle is set, plus a long hold when a test asks for one
   initial begin
      int stall;
      int r;
      forever begin
         if (rx_hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (rx_hold) @(posedge clock);
            rx_hold = 0;
         end else if (rx_idle) begin
            r = $urandom_range(0, 99);
            if (r >= 60) begin
               stall = (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         n_results++;
         if (expected_values.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %0d", $time, rsp_value);
            n_errors++;
         end else begin
            if (rsp_value !== expected_values[0]) begin
               $display("%0t: value mismatch, expected %0d actual %0d",
                        $time, expected_values[0], rsp_value);
               n_errors++;
            end
            void'(expected_values.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, expected_values.size());
         $display("[packed_nucleotide_store_counter] ERROR");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed_edges();
      test_full_backpressure();
      test_random_mix();
      test_drain_pause();
      req_valid <= 1'b0;
      wait_drained();
      repeat (30) @(posedge clock);
      $display("covered %0d sets, %0d gets, %0d counts and %0d ignored items",
               n_sets, n_gets, n_counts, n_ignored);
      $display("checked %0d results against the predicted store, %0d errors",
               n_results, n_errors);
      if (n_errors == 0)
         $display("[packed_nucleotide_store_counter] OK");
      else
         $display("[packed_nucleotide_store_counter] ERROR");
      $finish;
   end

endmodule
